// File: rtl/qlcs_pkg.sv
package qlcs_pkg;
  localparam int MAX_POINTS   = 64;
  localparam int ANCHOR_COUNT = 3;
  localparam int CW           = 24;
  localparam int NPW          = 7;
  localparam int CNTW         = $clog2(MAX_POINTS + 1);
  localparam int SPW          = 26;
  localparam int PRW          = SPW + CNTW;
  localparam logic signed [CW-1:0] Q8_MAX = 24'sh7FFFFF;
  localparam logic signed [CW-1:0] Q8_MIN = -24'sh800000;
  localparam logic [NPW-1:0] NUM_POINTS_RST = 7'd16;

  typedef struct packed {
    logic load;
    logic sort_step;
    logic div_start;
    logic div_step;
    logic mul_start;
    logic mul_step;
    logic raw_sel;
    logic next_point;
  } qlcs_cmd_t;

  typedef struct packed {
    logic raw_mode;
    logic div_done;
    logic mul_done;
  } qlcs_sts_t;
endpackage

// File: rtl/qlcs_if.sv
interface qlcs_in_if;
  import qlcs_pkg::*;
  logic valid;
  logic ready;
  logic signed [31:0] coef_a;
  logic signed [31:0] coef_b;
  logic signed [23:0] coef_c;
  logic signed [15:0] range_start;
  logic signed [15:0] range_end;
  logic signed [23:0] anchor0_x;
  logic signed [23:0] anchor0_y;
  logic signed [23:0] anchor1_x;
  logic signed [23:0] anchor1_y;
  logic signed [23:0] anchor2_x;
  logic signed [23:0] anchor2_y;
  modport source (output valid, coef_a, coef_b, coef_c, range_start, range_end,
    anchor0_x, anchor0_y, anchor1_x, anchor1_y, anchor2_x, anchor2_y, input ready);
  modport sink (input valid, coef_a, coef_b, coef_c, range_start, range_end,
    anchor0_x, anchor0_y, anchor1_x, anchor1_y, anchor2_x, anchor2_y, output ready);
endinterface

interface qlcs_out_if;
  logic valid;
  logic ready;
  logic signed [23:0] point_x;
  logic signed [23:0] point_y;
  logic last_point;
  modport source (output valid, point_x, point_y, last_point, input ready);
  modport sink (input valid, point_x, point_y, last_point, output ready);
endinterface

// File: rtl/qlcs_datapath.sv
module qlcs_datapath
  import qlcs_pkg::*;
(
  input  logic                 clk,
  input  qlcs_cmd_t            cmd,
  input  logic [NPW-1:0]       num_points,
  input  logic signed [31:0]   coef_a,
  input  logic signed [31:0]   coef_b,
  input  logic signed [CW-1:0] coef_c,
  input  logic signed [15:0]   range_start,
  input  logic signed [15:0]   range_end,
  input  logic signed [CW-1:0] anc_x [ANCHOR_COUNT],
  input  logic signed [CW-1:0] anc_y [ANCHOR_COUNT],
  output qlcs_sts_t            sts,
  output logic [CNTW-1:0]      npts,
  output logic signed [CW-1:0] pt_x,
  output logic signed [CW-1:0] pt_y
);
  logic signed [31:0]   a_r, b_r;
  logic signed [CW-1:0] c_r;
  logic signed [CW-1:0] ax_r [ANCHOR_COUNT];
  logic signed [CW-1:0] ay_r [ANCHOR_COUNT];
  logic signed [CW-1:0] ax_nxt [ANCHOR_COUNT];
  logic signed [CW-1:0] ay_nxt [ANCHOR_COUNT];
  logic signed [SPW-1:0] ylo_r, span_r;
  logic raw_r;
  logic [CNTW-1:0] n_r, idx_r;
  logic [CNTW-1:0] sidx_r;
  // divider
  logic [PRW-1:0] dq_r, drem_r;
  logic [CNTW-1:0] dcnt_r;
  logic dneg_r, ddone_r;
  logic [PRW:0] dtrial;
  logic signed [PRW:0] prod;
  // multiplier: y*y and b*y, then a*yy in two halves
  logic signed [CW-1:0] y_r;
  logic [2:0] mph_r;
  logic signed [47:0] yy_r;
  logic signed [56:0] ql_r;
  logic signed [80:0] qa_r;
  logic signed [56:0] lb_r;
  logic mdone_r;
  logic signed [50:0] xsum;
  logic signed [SPW-1:0] ycalc;

  always_comb begin
    for (int i = 0; i < ANCHOR_COUNT; i++) begin
      ax_nxt[i] = ax_r[i];
      ay_nxt[i] = ay_r[i];
    end
    // odd-even transposition pass; stable for equal keys
    for (int i = 0; i < ANCHOR_COUNT - 1; i++) begin
      if ((i % 2) == (sidx_r[0] ? 1 : 0) && ay_r[i] > ay_r[i+1]) begin
        ax_nxt[i] = ax_r[i+1]; ay_nxt[i] = ay_r[i+1];
        ax_nxt[i+1] = ax_r[i]; ay_nxt[i+1] = ay_r[i];
      end
    end
  end

  logic any;
  always_comb begin
    any = 1'b0;
    for (int i = 0; i < ANCHOR_COUNT; i++)
      if (anc_x[i] != '0 || anc_y[i] != '0) any = 1'b1;
  end

  logic [CNTW-1:0] nclamp;
  always_comb begin
    if (num_points < 7'd2) nclamp = CNTW'(2);
    else if (num_points > NPW'(MAX_POINTS)) nclamp = CNTW'(MAX_POINTS);
    else nclamp = CNTW'(num_points);
  end

  assign prod = (PRW+1)'(span_r) * $signed({1'b0, idx_r});
  assign dtrial = {drem_r, dq_r[PRW-1]} - (PRW+1)'(n_r - CNTW'(1));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      a_r <= coef_a; b_r <= coef_b; c_r <= coef_c;
      for (int i = 0; i < ANCHOR_COUNT; i++) begin
        ax_r[i] <= anc_x[i]; ay_r[i] <= anc_y[i];
      end
      raw_r <= 1'b0;
      sidx_r <= '0;
      idx_r <= '0;
      n_r <= nclamp;
      if (!any) begin
        ylo_r <= SPW'($signed({range_start, 8'd0}));
        span_r <= SPW'($signed({range_end, 8'd0})) - SPW'($signed({range_start, 8'd0}));
      end else begin
        ylo_r <= '0;
        span_r <= '0;
      end
    end
    if (cmd.sort_step) begin
      for (int i = 0; i < ANCHOR_COUNT; i++) begin
        ax_r[i] <= ax_nxt[i]; ay_r[i] <= ay_nxt[i];
      end
      sidx_r <= sidx_r + CNTW'(1);
      if (sidx_r == CNTW'(ANCHOR_COUNT - 1)) begin
        ylo_r <= SPW'(ay_nxt[0]);
        span_r <= SPW'(ay_nxt[ANCHOR_COUNT-1]) - SPW'(ay_nxt[0]);
        raw_r <= (ay_nxt[ANCHOR_COUNT-1] == ay_nxt[0]);
        if (ay_nxt[ANCHOR_COUNT-1] == ay_nxt[0]) n_r <= CNTW'(ANCHOR_COUNT);
      end
    end
    if (cmd.div_start) begin
      dneg_r <= prod[PRW];
      dq_r <= prod[PRW] ? PRW'(-prod) : PRW'(prod);
      drem_r <= '0;
      dcnt_r <= '0;
      ddone_r <= 1'b0;
    end else if (cmd.div_step && !ddone_r) begin
      if (!dtrial[PRW]) drem_r <= dtrial[PRW-1:0];
      else drem_r <= {drem_r[PRW-2:0], dq_r[PRW-1]};
      dq_r <= {dq_r[PRW-2:0], ~dtrial[PRW]};
      dcnt_r <= dcnt_r + CNTW'(1);
      if (dcnt_r == CNTW'(PRW - 1)) ddone_r <= 1'b1;
    end
    if (cmd.mul_start) begin
      y_r <= CW'(ycalc);
      mph_r <= 3'd0;
      mdone_r <= 1'b0;
    end else if (cmd.mul_step && !mdone_r) begin
      case (mph_r)
        3'd0: begin
          yy_r <= y_r * y_r;
          lb_r <= b_r * y_r;
          mph_r <= 3'd1;
        end
        3'd1: begin
          ql_r <= a_r * $signed({1'b0, yy_r[23:0]});
          mph_r <= 3'd2;
        end
        3'd2: begin
          qa_r <= (81'(a_r * $signed({1'b0, yy_r[47:24]})) <<< 24) + 81'(ql_r);
          mph_r <= 3'd3;
          mdone_r <= 1'b1;
        end
        default: mph_r <= 3'd0;
      endcase
    end
    if (cmd.next_point) idx_r <= idx_r + CNTW'(1);
  end

  assign ycalc = ylo_r + (dneg_r ? -SPW'(dq_r) : SPW'(dq_r));
  assign xsum = 51'(qa_r >>> 32) + 51'(lb_r >>> 24) + 51'(c_r);

  always_comb begin
    if (cmd.raw_sel) begin
      pt_x = ax_r[idx_r[$clog2(ANCHOR_COUNT)-1:0]];
      pt_y = ay_r[idx_r[$clog2(ANCHOR_COUNT)-1:0]];
    end else begin
      pt_y = y_r;
      if (xsum > 51'(Q8_MAX)) pt_x = Q8_MAX;
      else if (xsum < 51'(Q8_MIN)) pt_x = Q8_MIN;
      else pt_x = CW'(xsum);
    end
  end

  assign sts.raw_mode = raw_r;
  assign sts.div_done = ddone_r;
  assign sts.mul_done = mdone_r;
  assign npts = n_r;
endmodule

// File: rtl/qlcs_ctrl.sv
module qlcs_ctrl
  import qlcs_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic            any_anchor,
  input  qlcs_sts_t       sts,
  input  logic [CNTW-1:0] npts,
  output qlcs_cmd_t       cmd,
  input  logic            out_ready,
  output logic            out_valid,
  output logic            out_last
);
  localparam logic [2:0] S_IDLE = 3'd0, S_SORT = 3'd1, S_DIV = 3'd2, S_MUL = 3'd3,
                         S_EMIT = 3'd4, S_RAW = 3'd5;
  logic [2:0] state_r, state_nxt;
  logic [CNTW-1:0] sc_r, sc_nxt, pc_r, pc_nxt;

  always_comb begin
    state_nxt = state_r;
    sc_nxt = sc_r;
    pc_nxt = pc_r;
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    out_last = (pc_r == npts - CNTW'(1));
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          pc_nxt = '0;
          sc_nxt = '0;
          state_nxt = any_anchor ? S_SORT : S_RAW;
        end
      end
      S_SORT: begin
        cmd.sort_step = 1'b1;
        sc_nxt = sc_r + CNTW'(1);
        if (sc_r == CNTW'(ANCHOR_COUNT - 1)) state_nxt = S_RAW;
      end
      S_RAW: begin
        if (sts.raw_mode) begin
          cmd.raw_sel = 1'b1;
          out_valid = 1'b1;
          if (out_ready) begin
            cmd.next_point = 1'b1;
            pc_nxt = pc_r + CNTW'(1);
            if (out_last) state_nxt = S_IDLE;
          end
        end else begin
          cmd.div_start = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) begin
          cmd.mul_start = 1'b1;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul_step = 1'b1;
        if (sts.mul_done) state_nxt = S_EMIT;
      end
      S_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cmd.next_point = 1'b1;
          pc_nxt = pc_r + CNTW'(1);
          if (out_last) state_nxt = S_IDLE;
          else state_nxt = S_RAW;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      sc_r <= '0;
      pc_r <= '0;
    end else begin
      state_r <= state_nxt;
      sc_r <= sc_nxt;
      pc_r <= pc_nxt;
    end
  end
endmodule

// File: rtl/quadratic_lane_curve_sampler.sv
// Without anchors a request goes straight to sampling; with anchors, the anchors
// are sorted first and a raw anchor line is sent when they span no y range.
// Each sampled point goes through setup, divide, multiply and output steps;
// raw lines give one point per cycle while out_ready stays high.
// The next request is taken in the cycle after the last point goes out.
// Reset: synchronous active-low rst_n returns control to idle and num_points to 16.
module quadratic_lane_curve_sampler
  import qlcs_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [NPW-1:0]     cfg_wdata,
  qlcs_in_if.sink            in_ch,
  qlcs_out_if.source         out_ch
);
  logic [NPW-1:0] num_points_r;
  qlcs_cmd_t cmd;
  qlcs_sts_t sts;
  logic [CNTW-1:0] npts;
  logic any_anchor;
  logic signed [CW-1:0] anc_x [ANCHOR_COUNT];
  logic signed [CW-1:0] anc_y [ANCHOR_COUNT];

  always_ff @(posedge clk) begin
    if (!rst_n) num_points_r <= NUM_POINTS_RST;
    else if (cfg_we) num_points_r <= cfg_wdata;
  end

  assign anc_x[0] = in_ch.anchor0_x; assign anc_y[0] = in_ch.anchor0_y;
  assign anc_x[1] = in_ch.anchor1_x; assign anc_y[1] = in_ch.anchor1_y;
  assign anc_x[2] = in_ch.anchor2_x; assign anc_y[2] = in_ch.anchor2_y;
  assign any_anchor = (in_ch.anchor0_x != '0) || (in_ch.anchor0_y != '0) ||
                      (in_ch.anchor1_x != '0) || (in_ch.anchor1_y != '0) ||
                      (in_ch.anchor2_x != '0) || (in_ch.anchor2_y != '0);

  qlcs_ctrl u_ctrl (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .any_anchor, .sts, .npts, .cmd,
    .out_ready(out_ch.ready), .out_valid(out_ch.valid), .out_last(out_ch.last_point)
  );

  qlcs_datapath u_dp (
    .clk, .cmd, .num_points(num_points_r),
    .coef_a(in_ch.coef_a), .coef_b(in_ch.coef_b), .coef_c(in_ch.coef_c),
    .range_start(in_ch.range_start), .range_end(in_ch.range_end),
    .anc_x, .anc_y, .sts, .npts,
    .pt_x(out_ch.point_x), .pt_y(out_ch.point_y)
  );
endmodule
